>>> rtl/assert_macros.svh
// assertion macros used by the queue rtl
// depends on nothing; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DFQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define DFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

// expression must never hold
`define DFQ_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("check failed: forbidden condition");

`endif

>>> rtl/dfq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the deduplicating queue
// no dependencies; imported by every module of the block but dfq_ram
package dfq_pkg;

    localparam int ID_SPACE_DEF    = 65536;
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int TAG_BITS_DEF    = 32;
    localparam int ID_BITS         = 16;
    localparam int TAG_PORT_BITS   = 32;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSHED = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_POPPED = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef struct packed {
        logic                     action;
        logic [ID_BITS-1:0]       item_id;
        logic [TAG_PORT_BITS-1:0] tag;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic [ID_BITS-1:0]       out_id;
        logic [TAG_PORT_BITS-1:0] out_tag;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MOD,
        S_LOOK,
        S_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic load_item;
        logic mul_en;
        logic mod_en;
        logic map_re;
        logic entry_re;
        logic exec_en;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic cmd_pop;
        logic out_free;
    } ctl_sts_t;

endpackage

>>> rtl/dfq_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dfq_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// datapath: item registers, slot reduction, bitmap and entry rams, ring pointers
// depends on dfq_pkg, dfq_ram and assert_macros.svh
module dfq_datapath #(
    parameter int ID_SPACE    = dfq_pkg::ID_SPACE_DEF,
    parameter int QUEUE_DEPTH = dfq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = dfq_pkg::TAG_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dfq_pkg::cmd_t     cmd,
    output dfq_pkg::rsp_t     rsp,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  dfq_pkg::ctl_cmd_t ctl,
    output dfq_pkg::ctl_sts_t sts
);

    import dfq_pkg::*;

    localparam int MAP_AW = $clog2(ID_SPACE);
    localparam int QAW    = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int EW     = ID_BITS + MAP_AW + TAG_BITS;
    // floor(2^32 / ID_SPACE); estimate is at most one short of the quotient
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / ID_SPACE);
    localparam logic [17:0] SPACE_W = 18'(ID_SPACE);

    logic                     item_action_reg;
    logic [ID_BITS-1:0]       item_id_reg;
    logic [TAG_PORT_BITS-1:0] item_tag_reg;
    logic [47:0]              prod_reg;
    logic [47:0]              prod_next;
    logic [MAP_AW-1:0]        slot_reg;
    logic [MAP_AW-1:0]        slot_next;
    logic [QAW-1:0]           head_reg;
    logic [QAW-1:0]           head_next;
    logic [QAW-1:0]           tail_reg;
    logic [QAW-1:0]           tail_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [MAP_AW-1:0]        clr_idx_reg;
    logic [MAP_AW-1:0]        clr_idx_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    logic [15:0]              q_est;
    logic [33:0]              qd_full;
    logic [17:0]              rem_est;
    logic [17:0]              rem_fix;
    logic [63:0]              tag_wide;
    logic [63:0]              ent_tag_wide;

    logic                     map_we;
    logic [MAP_AW-1:0]        map_waddr;
    logic [0:0]               map_wdata;
    logic [0:0]               map_rdata;
    logic                     entry_we;
    logic [EW-1:0]            entry_wdata;
    logic [EW-1:0]            entry_rdata;
    logic [ID_BITS-1:0]       ent_id;
    logic [MAP_AW-1:0]        ent_slot;
    logic [TAG_BITS-1:0]      ent_tag;

    logic                     is_pop;
    logic                     dup;
    logic                     full;
    logic                     empty;
    logic                     push_ok;
    logic                     pop_ok;
    logic [CW:0]              tail_sum;
    logic [CW:0]              tail_chk;

    // slot = item_id mod ID_SPACE by reciprocal multiply and one correction
    assign prod_next = 48'(item_id_reg) * 48'(RECIP);
    assign q_est     = prod_reg[47:32];
    assign qd_full   = 34'(q_est) * 34'(ID_SPACE);
    assign rem_est   = 18'(item_id_reg) - qd_full[17:0];
    assign rem_fix   = (rem_est >= SPACE_W) ? (rem_est - SPACE_W) : rem_est;
    assign slot_next = rem_fix[MAP_AW-1:0];

    // entry layout: id, bitmap slot, tag
    assign tag_wide     = 64'(item_tag_reg);
    assign entry_wdata  = {item_id_reg, slot_reg, tag_wide[TAG_BITS-1:0]};
    assign ent_id       = entry_rdata[EW-1 -: ID_BITS];
    assign ent_slot     = entry_rdata[TAG_BITS +: MAP_AW];
    assign ent_tag      = entry_rdata[TAG_BITS-1:0];
    assign ent_tag_wide = 64'(ent_tag);

    always_comb
    begin
        is_pop  = (item_action_reg == ACT_POP);
        dup     = map_rdata[0];
        full    = (count_reg == CW'(QUEUE_DEPTH));
        empty   = (count_reg == '0);
        push_ok = !is_pop && !dup && !full;
        pop_ok  = is_pop && !empty;

        rsp_next.status  = ST_PUSHED;
        rsp_next.out_id  = '0;
        rsp_next.out_tag = '0;
        if (is_pop)
        begin
            if (empty)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_next.status  = ST_POPPED;
                rsp_next.out_id  = ent_id;
                rsp_next.out_tag = ent_tag_wide[TAG_PORT_BITS-1:0];
            end
        end
        else if (dup)
        begin
            rsp_next.status = ST_DUP;
        end
        else if (full)
        begin
            rsp_next.status = ST_FULL;
        end
    end

    // bitmap: clearing pass, set on push, clear on pop
    always_comb
    begin
        map_we    = ctl.clr_en || (ctl.exec_en && (push_ok || pop_ok));
        map_waddr = slot_reg;
        map_wdata = 1'b0;
        if (ctl.clr_en)
        begin
            map_waddr = clr_idx_reg;
        end
        else if (pop_ok)
        begin
            map_waddr = ent_slot;
        end
        else
        begin
            map_wdata = 1'b1;
        end
    end

    assign entry_we = ctl.exec_en && push_ok;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        clr_idx_next   = clr_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        if (ctl.clr_en)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end
        if (ctl.exec_en && push_ok)
        begin
            tail_next  = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (ctl.exec_en && pop_ok)
        begin
            head_next  = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctl.exec_en)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_action_reg <= cmd.action;
            item_id_reg     <= cmd.item_id;
            item_tag_reg    <= cmd.tag;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.mod_en)
        begin
            slot_reg <= slot_next;
        end
        if (ctl.exec_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    dfq_ram #(
        .WIDTH (1),
        .DEPTH (ID_SPACE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (ctl.map_re),
        .raddr (slot_reg),
        .rdata (map_rdata)
    );

    dfq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (tail_reg),
        .wdata (entry_wdata),
        .re    (ctl.entry_re),
        .raddr (head_reg),
        .rdata (entry_rdata)
    );

    assign sts.clr_done = (clr_idx_reg == MAP_AW'(ID_SPACE - 1));
    assign sts.cmd_pop  = (cmd.action == ACT_POP);
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp          = rsp_reg;
    assign rsp_valid    = rsp_valid_reg;

    // tail must sit count entries past head around the ring
    assign tail_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail_chk = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                      (tail_sum - (CW + 1)'(QUEUE_DEPTH)) : tail_sum;

    `DFQ_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CW'(QUEUE_DEPTH))
    `DFQ_ASSERT_IMP(a_ring_tail, clk, rst_n, 1'b1, tail_chk == (CW + 1)'(tail_reg))
    `DFQ_ASSERT_NEXT(a_push_count, clk, rst_n, ctl.exec_en && push_ok, count_reg == CW'($past(count_reg) + 1'b1))

endmodule

>>> rtl/dfq_ctrl.sv
`timescale 1ns / 1ps
// controller: clearing pass, per-word sequencing, handshake on the command side
// depends on dfq_pkg
module dfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output dfq_pkg::ctl_cmd_t ctl,
    input  dfq_pkg::ctl_sts_t sts
);

    import dfq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = sts.cmd_pop ? S_EXEC : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_stall = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_en = 1'b1;
            end
            S_IDLE:
            begin
                cmd_stall     = 1'b0;
                ctl.load_item = cmd_valid;
                ctl.entry_re  = 1'b1;
            end
            S_MUL:
            begin
                ctl.mul_en = 1'b1;
            end
            S_MOD:
            begin
                ctl.mod_en = 1'b1;
            end
            S_LOOK:
            begin
                ctl.map_re = 1'b1;
            end
            S_EXEC:
            begin
                ctl.exec_en = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/dedup_fifo_queue_unit.sv
`timescale 1ns / 1ps
// top level of the deduplicating queue: controller plus datapath
// depends on dfq_pkg, dfq_ctrl, dfq_datapath, dfq_ram
//
// A first-in first-out queue of ids with tags that refuses an id already
// queued. Each command word gives exactly one response word: pushed,
// duplicate ignored, full refused, popped (with id and tag) or empty. After
// reset the presence bitmap is swept clear, one entry a cycle, and
// cmd_stall stays high until the sweep is done. Then one word is handled
// at a time: a pop goes from acceptance straight to its commit, while a
// push first passes the two-stage reduction of the id to its bitmap
// slot (reciprocal multiply, then subtract and correct) and the registered
// read of the bitmap ram. A finished response sits in an output register,
// so the next command word is taken while it waits; a command only stalls
// at its last step if that register is still full.
module dedup_fifo_queue_unit #(
    parameter int ID_SPACE    = dfq_pkg::ID_SPACE_DEF,
    parameter int QUEUE_DEPTH = dfq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = dfq_pkg::TAG_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  dfq_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dfq_pkg::rsp_t rsp
);

    import dfq_pkg::*;

    // command and status between the two halves
    ctl_cmd_t ctl;
    ctl_sts_t sts;

    // sequencing: clearing sweep, slot reduction, bitmap lookup, commit
    dfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // storage: bitmap ram, ring of entries, head/tail/count, output register
    dfq_datapath #(
        .ID_SPACE    (ID_SPACE),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
